@@ src/coprime_count_table_core_macros.svh @@
// Assertion macros used by the checker file of coprime_count_table_core.
// No dependencies.
`ifndef COPRIME_COUNT_TABLE_CORE_MACROS_SVH
`define COPRIME_COUNT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cct check failed");

// Next-cycle implication, disabled while reset is low
`define CCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cct check failed");

`endif

@@ src/cct_pkg.sv @@
// Shared types, constants and command codes of the coprime count table core.
// No dependencies.
`timescale 1ns / 1ps

package cct_pkg;

    // Table size
    localparam int MAX_LIMIT = 4096;
    localparam int DEPTH     = MAX_LIMIT + 1;
    localparam int AW        = $clog2(DEPTH);
    localparam int JW        = AW + 1;
    localparam int NW        = 13;
    localparam int VAL_W     = 12;
    localparam int ACC_W     = 18;
    localparam int SV_W      = 3;

    // Result status codes
    localparam logic [1:0] ST_BUILD_DONE = 2'd0;
    localparam logic [1:0] ST_READ_OK    = 2'd1;
    localparam logic [1:0] ST_READ_ERR   = 2'd2;

    // Opcodes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Mobius class codes kept in the sieve memory
    localparam logic [1:0] MU_ZERO = 2'd0;
    localparam logic [1:0] MU_ODD  = 2'd1;
    localparam logic [1:0] MU_EVEN = 2'd2;

    typedef struct packed {
        logic          opcode;
        logic [NW-1:0] entry_index;
    } t_in_req;

    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic [1:0]       status;
    } t_out_req;

    // Controller commands
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE     = 4'd0;
    localparam t_cmd CMD_START    = 4'd1;
    localparam t_cmd CMD_INIT     = 4'd2;
    localparam t_cmd CMD_SV_OUTER = 4'd3;
    localparam t_cmd CMD_SV_CHK   = 4'd4;
    localparam t_cmd CMD_SV_RD    = 4'd5;
    localparam t_cmd CMD_SV_WR    = 4'd6;
    localparam t_cmd CMD_MU_OUTER = 4'd7;
    localparam t_cmd CMD_MU_CHK   = 4'd8;
    localparam t_cmd CMD_CNT      = 4'd9;
    localparam t_cmd CMD_AC_RD    = 4'd10;
    localparam t_cmd CMD_AC_WR    = 4'd11;
    localparam t_cmd CMD_FINISH   = 4'd12;
    localparam t_cmd CMD_RD_ISSUE = 4'd13;
    localparam t_cmd CMD_RD_DONE  = 4'd14;

    // Datapath status seen by the controller
    typedef struct packed {
        logic in_is_read;
        logic out_free;
        logic init_last;
        logic i_gt_n;
        logic marked;
        logic mu_zero;
        logic j_gt_n;
        logic t_gt_n;
        logic j_ge_n;
    } t_dp_status;

endpackage

@@ src/cct_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cct_dpath.sv @@
// Datapath: limit register, loop counters, sieve and count memories, result register.
// Depends on cct_pkg and cct_ram.
`timescale 1ns / 1ps

module cct_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cct_pkg::t_cmd     i_cmd,
    input  cct_pkg::t_in_req  i_in_data,
    input  logic              i_cfg_we,
    input  logic [cct_pkg::NW-1:0] i_cfg_data,
    input  logic              i_out_ready,
    output cct_pkg::t_dp_status o_status,
    output logic              o_out_valid,
    output cct_pkg::t_out_req o_out_data
);

    localparam int AW    = cct_pkg::AW;
    localparam int JW    = cct_pkg::JW;
    localparam int NW    = cct_pkg::NW;
    localparam int ACC_W = cct_pkg::ACC_W;
    localparam int SV_W  = cct_pkg::SV_W;
    localparam int VAL_W = cct_pkg::VAL_W;
    localparam logic [NW-1:0] LIM_MAX = NW'(cct_pkg::MAX_LIMIT);

    logic [NW-1:0]    r_limit;
    logic [AW-1:0]    r_bn, r_built_n, r_i, r_c, r_q;
    logic [JW-1:0]    r_j, r_t;
    logic             r_built, r_odd, r_err, r_out_valid;
    cct_pkg::t_out_req r_out;

    logic             sv_we, ac_we;
    logic [AW-1:0]    sv_waddr, sv_raddr, ac_raddr;
    logic [SV_W-1:0]  sv_wdata, sv_rdata;
    logic [ACC_W-1:0] ac_wdata, ac_rdata, ac_init, q_ext;
    logic [1:0]       mu_new;
    logic [AW-1:0]    c_inc;
    logic             init_last, i_gt_n, j_gt_n, j_ge_n, t_gt_n;
    logic             rd_err;

    // Loop compares
    assign init_last = (r_i == r_bn);
    assign i_gt_n    = (r_i > r_bn);
    assign j_gt_n    = (r_j > {1'b0, r_bn});
    assign j_ge_n    = (r_j >= {1'b0, r_bn});
    assign t_gt_n    = (r_t > {1'b0, r_bn});
    assign c_inc     = r_c + AW'(1);

    assign o_status.in_is_read = (i_in_data.opcode == cct_pkg::OP_READ);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.init_last  = init_last;
    assign o_status.i_gt_n     = i_gt_n;
    assign o_status.marked     = sv_rdata[SV_W-1];
    assign o_status.mu_zero    = (sv_rdata[1:0] == cct_pkg::MU_ZERO);
    assign o_status.j_gt_n     = j_gt_n;
    assign o_status.t_gt_n     = t_gt_n;
    assign o_status.j_ge_n     = j_ge_n;

    // Sieve memory: {marked, mobius class}
    always_comb begin
        if (c_inc == r_i || r_c == '0) begin
            mu_new = cct_pkg::MU_ZERO;
        end else begin
            mu_new = sv_rdata[1:0];
        end
        // multiple of i squared when the multiplier k is a multiple of i
        if (r_c == '0) begin
            mu_new = cct_pkg::MU_ZERO;
        end else if (sv_rdata[1:0] == cct_pkg::MU_ODD) begin
            mu_new = cct_pkg::MU_EVEN;
        end else if (sv_rdata[1:0] == cct_pkg::MU_EVEN) begin
            mu_new = cct_pkg::MU_ODD;
        end else begin
            mu_new = cct_pkg::MU_ZERO;
        end
    end

    assign sv_we    = (i_cmd == cct_pkg::CMD_INIT) || (i_cmd == cct_pkg::CMD_SV_WR);
    assign sv_waddr = (i_cmd == cct_pkg::CMD_INIT) ? r_i : r_j[AW-1:0];
    assign sv_wdata = (i_cmd == cct_pkg::CMD_INIT) ? {1'b0, cct_pkg::MU_EVEN}
                                                   : {1'b1, mu_new};
    assign sv_raddr = (i_cmd == cct_pkg::CMD_SV_RD) ? r_j[AW-1:0] : r_i;

    // Count accumulator memory
    assign ac_init  = (r_i == '0) ? '0 : ACC_W'(r_bn - r_i);
    assign q_ext    = ACC_W'(r_q);
    assign ac_we    = (i_cmd == cct_pkg::CMD_INIT) || (i_cmd == cct_pkg::CMD_AC_WR);
    assign ac_wdata = (i_cmd == cct_pkg::CMD_INIT) ? ac_init
                    : (r_odd ? ac_rdata - q_ext : ac_rdata + q_ext);
    assign ac_raddr = (i_cmd == cct_pkg::CMD_RD_ISSUE) ? i_in_data.entry_index[AW-1:0]
                                                      : r_j[AW-1:0];

    assign rd_err = !r_built || (i_in_data.entry_index == '0)
                    || (i_in_data.entry_index > NW'(r_built_n));

    cct_ram #(.WIDTH(SV_W), .DEPTH(cct_pkg::DEPTH)) u_sieve_ram (
        .i_clk   (i_clk),
        .i_we    (sv_we),
        .i_waddr (sv_waddr),
        .i_wdata (sv_wdata),
        .i_raddr (sv_raddr),
        .o_rdata (sv_rdata)
    );

    cct_ram #(.WIDTH(ACC_W), .DEPTH(cct_pkg::DEPTH)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ac_we),
        .i_waddr (sv_waddr),
        .i_wdata (ac_wdata),
        .i_raddr (ac_raddr),
        .o_rdata (ac_rdata)
    );

    // Control state: limit, built flag, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= NW'(1);
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_data == '0) begin
                    r_limit <= NW'(1);
                end else if (i_cfg_data > LIM_MAX) begin
                    r_limit <= LIM_MAX;
                end else begin
                    r_limit <= i_cfg_data;
                end
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd == cct_pkg::CMD_FINISH || i_cmd == cct_pkg::CMD_RD_DONE) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd == cct_pkg::CMD_FINISH) begin
                r_built <= 1'b1;
            end
        end
    end

    // Loop counters and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            cct_pkg::CMD_START: begin
                r_i  <= '0;
                r_bn <= AW'(r_limit);
            end
            cct_pkg::CMD_INIT: begin
                r_i <= init_last ? AW'(2) : r_i + AW'(1);
            end
            cct_pkg::CMD_SV_OUTER: begin
                if (i_gt_n) begin
                    r_i <= AW'(2);
                end
            end
            cct_pkg::CMD_SV_CHK: begin
                if (sv_rdata[SV_W-1]) begin
                    r_i <= r_i + AW'(1);
                end else begin
                    r_j <= JW'(r_i);
                    r_c <= AW'(1);
                end
            end
            cct_pkg::CMD_SV_RD: begin
                if (j_gt_n) begin
                    r_i <= r_i + AW'(1);
                end
            end
            cct_pkg::CMD_SV_WR: begin
                r_j <= r_j + JW'(r_i);
                r_c <= (c_inc == r_i) ? '0 : c_inc;
            end
            cct_pkg::CMD_MU_CHK: begin
                if (sv_rdata[1:0] == cct_pkg::MU_ZERO) begin
                    r_i <= r_i + AW'(1);
                end else begin
                    r_t   <= JW'(r_i) + JW'(r_i);
                    r_q   <= '0;
                    r_odd <= (sv_rdata[1:0] == cct_pkg::MU_ODD);
                end
            end
            cct_pkg::CMD_CNT: begin
                // q ends at floor(n/d) - 1, the term of the first multiple
                if (!t_gt_n) begin
                    r_q <= r_q + AW'(1);
                    r_t <= r_t + JW'(r_i);
                end else begin
                    r_j <= JW'(r_i);
                end
            end
            cct_pkg::CMD_AC_RD: begin
                if (j_ge_n) begin
                    r_i <= r_i + AW'(1);
                end
            end
            cct_pkg::CMD_AC_WR: begin
                r_j <= r_j + JW'(r_i);
                r_q <= r_q - AW'(1);
            end
            cct_pkg::CMD_FINISH: begin
                r_built_n         <= r_bn;
                r_out.entry_value <= '0;
                r_out.status      <= cct_pkg::ST_BUILD_DONE;
            end
            cct_pkg::CMD_RD_ISSUE: begin
                r_err <= rd_err;
            end
            cct_pkg::CMD_RD_DONE: begin
                if (r_err) begin
                    r_out.entry_value <= '0;
                    r_out.status      <= cct_pkg::ST_READ_ERR;
                end else begin
                    r_out.entry_value <= ac_rdata[ACC_W-1] ? '0 : ac_rdata[VAL_W-1:0];
                    r_out.status      <= cct_pkg::ST_READ_OK;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/cct_ctrl.sv @@
// Controller state machine: sequences build sweeps and table reads.
// Depends on cct_pkg.
`timescale 1ns / 1ps

module cct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cct_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output cct_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_SV_OUTER = 4'd2;
    localparam logic [3:0] S_SV_CHK   = 4'd3;
    localparam logic [3:0] S_SV_RD    = 4'd4;
    localparam logic [3:0] S_SV_WR    = 4'd5;
    localparam logic [3:0] S_MU_OUTER = 4'd6;
    localparam logic [3:0] S_MU_CHK   = 4'd7;
    localparam logic [3:0] S_CNT      = 4'd8;
    localparam logic [3:0] S_AC_RD    = 4'd9;
    localparam logic [3:0] S_AC_WR    = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;
    localparam logic [3:0] S_RD_DONE  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = o_in_ready && i_in_valid;

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_cmd   = cct_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.in_is_read) begin
                        o_cmd   = cct_pkg::CMD_RD_ISSUE;
                        n_state = S_RD_DONE;
                    end else begin
                        o_cmd   = cct_pkg::CMD_START;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd = cct_pkg::CMD_INIT;
                if (i_status.init_last) n_state = S_SV_OUTER;
            end
            S_SV_OUTER: begin
                o_cmd   = cct_pkg::CMD_SV_OUTER;
                n_state = i_status.i_gt_n ? S_MU_OUTER : S_SV_CHK;
            end
            S_SV_CHK: begin
                o_cmd   = cct_pkg::CMD_SV_CHK;
                n_state = i_status.marked ? S_SV_OUTER : S_SV_RD;
            end
            S_SV_RD: begin
                o_cmd   = cct_pkg::CMD_SV_RD;
                n_state = i_status.j_gt_n ? S_SV_OUTER : S_SV_WR;
            end
            S_SV_WR: begin
                o_cmd   = cct_pkg::CMD_SV_WR;
                n_state = S_SV_RD;
            end
            S_MU_OUTER: begin
                o_cmd   = cct_pkg::CMD_MU_OUTER;
                n_state = i_status.i_gt_n ? S_FINISH : S_MU_CHK;
            end
            S_MU_CHK: begin
                o_cmd   = cct_pkg::CMD_MU_CHK;
                n_state = i_status.mu_zero ? S_MU_OUTER : S_CNT;
            end
            S_CNT: begin
                o_cmd = cct_pkg::CMD_CNT;
                if (i_status.t_gt_n) n_state = S_AC_RD;
            end
            S_AC_RD: begin
                o_cmd   = cct_pkg::CMD_AC_RD;
                n_state = i_status.j_ge_n ? S_MU_OUTER : S_AC_WR;
            end
            S_AC_WR: begin
                o_cmd   = cct_pkg::CMD_AC_WR;
                n_state = S_AC_RD;
            end
            S_FINISH: begin
                o_cmd   = cct_pkg::CMD_FINISH;
                n_state = S_IDLE;
            end
            S_RD_DONE: begin
                o_cmd   = cct_pkg::CMD_RD_DONE;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/coprime_count_table_core.sv @@
// Top level of the coprime count table core: controller plus datapath.
// Depends on cct_pkg, cct_ctrl, cct_dpath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_ready   | i_in_data  (opcode, index)
//  out     | out       | o_out_valid / i_out_ready | o_out_data (value, status)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (limit_n)
//
// A read request costs one registered read of the count memory: the read is
// issued on the accepting edge, the result register is loaded from the read
// data in the S_RD_DONE state, and the next request waits until the controller
// is back in idle. A build for limit n runs the init sweep, the sieve
// read-modify-write loop, and per squarefree d a quotient count plus a
// read-modify-write over its multiples. Reset is synchronous, active low; no
// clearing pass, the memories are filled by the first build. A new request is
// taken only when idle and the result register is free or being drained.
// Config writes are always taken.
`timescale 1ns / 1ps

module coprime_count_table_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  cct_pkg::t_in_req       i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output cct_pkg::t_out_req      o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [cct_pkg::NW-1:0] i_cfg_data
);

    cct_pkg::t_cmd       cmd;
    cct_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    cct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    cct_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/cct_checker.sv @@
// Port-level checks for coprime_count_table_core, bound to the top level.
// Depends on cct_pkg and coprime_count_table_core_macros.svh.
`timescale 1ns / 1ps
`include "coprime_count_table_core_macros.svh"

module cct_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input cct_pkg::t_out_req      o_out_data
);

    // Error and build results carry a zero value
    `CCT_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status == cct_pkg::ST_READ_ERR, o_out_data.entry_value == '0)
    `CCT_ASSERT_IMP(a_build_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status == cct_pkg::ST_BUILD_DONE, o_out_data.entry_value == '0)
    // No new request while a result is stuck
    `CCT_ASSERT_IMP(a_no_take_stalled, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    // A stalled result holds
    `CCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind coprime_count_table_core cct_checker u_cct_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for coprime_count_table_core: directed rows, then random
// build/read phases, all checked against a behavioral table model. Uses cct_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int NW          = cct_pkg::NW;
    localparam int VAL_W       = cct_pkg::VAL_W;
    localparam int MAX_LIMIT   = cct_pkg::MAX_LIMIT;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    cct_pkg::t_in_req  i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b1;
    cct_pkg::t_out_req o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [NW-1:0]     i_cfg_data = '0;

    coprime_count_table_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Directed rows: optional register write before the item, optional typed result
    typedef struct {
        int          cfg;      // -1: no write
        logic        op;
        int          idx;
        bit          typed;
        int          val;
        logic [1:0]  st;
    } t_row;

    // Table model state
    int                lpf_tab [0:MAX_LIMIT];
    int                count_tab [0:MAX_LIMIT];
    bit                tab_built = 1'b0;
    int                tab_n = 0;
    int                cfg_limit = 1;
    cct_pkg::t_out_req pending_q [$];
    t_row              rows_q [$];
    int                errors = 0;
    int                cycles = 0;
    bit                in_calm = 1'b0;

    // Queue an expected result at the tail
    function automatic void add_pending(cct_pkg::t_out_req r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Sieve, then Mobius inclusion-exclusion over squarefree d >= 2
    function automatic void build_counts(int n);
        int acc [0:MAX_LIMIT];
        int x, p, prev, cnt, cls;
        bit sqf;
        for (int i = 0; i <= n; i++) lpf_tab[i] = 1;
        for (int i = 2; i <= n; i++) begin
            if (lpf_tab[i] == 1) begin
                lpf_tab[i] = i;
                for (int j = i * i; j <= n; j += i)
                    if (lpf_tab[j] == 1) lpf_tab[j] = i;
            end
        end
        acc[0] = 0;
        for (int i = 1; i <= n; i++) acc[i] = n - i;
        for (int d = 2; d <= n; d++) begin
            x = d; prev = 0; cnt = 0; sqf = 1'b1;
            while (x > 1 && sqf) begin
                p = lpf_tab[x];
                if (p == prev) sqf = 1'b0;
                prev = p; cnt++; x = x / p;
            end
            if (sqf) begin
                cls = cnt & 1;
                for (int j = d; j < n; j += d)
                    acc[j] += cls ? -((n - j) / d) : ((n - j) / d);
            end
        end
        for (int i = 0; i <= n; i++) count_tab[i] = (acc[i] < 0) ? 0 : acc[i];
        tab_n = n;
        tab_built = 1'b1;
    endfunction

    // Expected result of one accepted request
    function automatic cct_pkg::t_out_req predict_entry(cct_pkg::t_in_req req);
        cct_pkg::t_out_req r;
        r = '0;
        if (req.opcode == cct_pkg::OP_BUILD) begin
            build_counts(cfg_limit);
            r.status = cct_pkg::ST_BUILD_DONE;
        end else if (!tab_built || req.entry_index < 1 || req.entry_index > tab_n) begin
            r.status = cct_pkg::ST_READ_ERR;
        end else begin
            r.entry_value = count_tab[req.entry_index][VAL_W-1:0];
            r.status = cct_pkg::ST_READ_OK;
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL coprime_count_table_core");
            $finish;
        end
    end

    // Result side: random stalls, compare against oldest expectation
    int out_stall = 0;
    int out_seen = 0;
    always @(posedge i_clk) begin
        cct_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", o_out_data.status, -1);
            end else begin
                want = pending_q.pop_front();
                if (o_out_data.status !== want.status)
                    report("status", o_out_data.status, want.status);
                if (o_out_data.entry_value !== want.entry_value)
                    report("entry_value", o_out_data.entry_value, want.entry_value);
            end
            out_seen++;
            out_stall = ((out_seen % 150) < 40) ? 0 : int'($urandom_range(0, 10));
            if (out_stall > 0) i_out_ready <= 1'b0;
        end else if (!i_out_ready) begin
            if (out_stall > 0) out_stall--;
            if (out_stall == 0) i_out_ready <= 1'b1;
        end
    end

    // Send one request; valid stays high across back-to-back items
    task automatic send_req(logic op, logic [NW-1:0] idx);
        int gap;
        cct_pkg::t_in_req req;
        gap = in_calm ? 0 : int'($urandom_range(0, 10));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.opcode = op;
        req.entry_index = idx;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        add_pending(predict_entry(req));
    endtask

    // Register write once the block has drained
    task automatic write_limit(logic [NW-1:0] value);
        int v;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        v = int'(value);
        if (v < 1) v = 1;
        if (v > MAX_LIMIT) v = MAX_LIMIT;
        cfg_limit = v;
    endtask

    function automatic t_row row(int cfg, logic op, int idx, bit typed = 1'b0,
                                 int val = 0, logic [1:0] st = cct_pkg::ST_READ_OK);
        t_row r;
        r.cfg = cfg; r.op = op; r.idx = idx; r.typed = typed; r.val = val; r.st = st;
        return r;
    endfunction

    // Append one directed row
    function automatic void add_row(int cfg, logic op, int idx, bit typed = 1'b0,
                                    int val = 0, logic [1:0] st = cct_pkg::ST_READ_OK);
        rows_q.insert(rows_q.size(), row(cfg, op, idx, typed, val, st));
    endfunction

    initial begin
        cct_pkg::t_out_req got_pred;
        int n, reads, lim;
        add_row(-1, cct_pkg::OP_READ, 1, 1'b1, 0, cct_pkg::ST_READ_ERR);      // read before build
        add_row(-1, cct_pkg::OP_BUILD, 8191, 1'b1, 0, cct_pkg::ST_BUILD_DONE); // reset limit 1
        add_row(-1, cct_pkg::OP_READ, 1, 1'b1, 0, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 0, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(-1, cct_pkg::OP_READ, 2, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(0, cct_pkg::OP_BUILD, 0, 1'b1, 0, cct_pkg::ST_BUILD_DONE);    // zero limit -> 1
        add_row(-1, cct_pkg::OP_READ, 2, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(8191, cct_pkg::OP_BUILD, 0, 1'b1, 0, cct_pkg::ST_BUILD_DONE); // clamp to max
        add_row(-1, cct_pkg::OP_READ, 4096, 1'b1, 0, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 1, 1'b1, 4095, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 4097, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(-1, cct_pkg::OP_READ, 8191, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(-1, cct_pkg::OP_READ, 2);
        add_row(-1, cct_pkg::OP_READ, 4095);
        add_row(-1, cct_pkg::OP_READ, 2310);
        add_row(10, cct_pkg::OP_READ, 100);                                    // stale table kept
        add_row(-1, cct_pkg::OP_BUILD, 5, 1'b1, 0, cct_pkg::ST_BUILD_DONE);
        add_row(-1, cct_pkg::OP_READ, 10, 1'b1, 0, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 11, 1'b1, 0, cct_pkg::ST_READ_ERR);
        add_row(-1, cct_pkg::OP_READ, 1, 1'b1, 9, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 6);
        add_row(2, cct_pkg::OP_BUILD, 0, 1'b1, 0, cct_pkg::ST_BUILD_DONE);
        add_row(-1, cct_pkg::OP_READ, 1, 1'b1, 1, cct_pkg::ST_READ_OK);
        add_row(-1, cct_pkg::OP_READ, 2, 1'b1, 0, cct_pkg::ST_READ_OK);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (rows_q[k]) begin
            if (rows_q[k].cfg >= 0) write_limit(NW'(rows_q[k].cfg));
            send_req(rows_q[k].op, NW'(rows_q[k].idx));
            if (rows_q[k].typed) begin
                got_pred = pending_q[$];
                if (got_pred.status !== rows_q[k].st || got_pred.entry_value !== rows_q[k].val)
                    report("directed row model", k, rows_q[k].val);
                pending_q[$].status = rows_q[k].st;
                pending_q[$].entry_value = VAL_W'(rows_q[k].val);
            end
        end

        // Random phases: new limit, build, then mostly in-range reads
        for (int ph = 0; ph < 20; ph++) begin
            in_calm = (ph % 4 == 3);
            case ($urandom_range(0, 9))
                0:       lim = $urandom_range(0, 2);
                1:       lim = $urandom_range(100, 400);
                default: lim = $urandom_range(3, 64);
            endcase
            if (ph == 9) lim = $urandom_range(4097, 8191);
            write_limit(NW'(lim));
            if (ph % 5 == 4) send_req(cct_pkg::OP_READ, NW'($urandom_range(0, 8191))); // stale reads
            send_req(cct_pkg::OP_BUILD, NW'($urandom_range(0, 8191)));
            n = cfg_limit;
            reads = $urandom_range(70, 90);
            for (int r = 0; r < reads; r++) begin
                case ($urandom_range(0, 19))
                    0:       send_req(cct_pkg::OP_BUILD, NW'($urandom_range(0, 8191)));
                    1, 2:    send_req(cct_pkg::OP_READ, NW'($urandom_range(0, 8191)));
                    3:       send_req(cct_pkg::OP_READ, NW'($urandom_range(0, 1) ? n : n + 1));
                    default: send_req(cct_pkg::OP_READ, NW'($urandom_range(1, n)));
                endcase
            end
        end
        i_in_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS coprime_count_table_core");
        end else begin
            $display("FAIL coprime_count_table_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/cct_pkg.sv
src/cct_ram.sv
src/cct_dpath.sv
src/cct_ctrl.sv
src/coprime_count_table_core.sv
src/cct_checker.sv
tb/testbench.sv
